// ----- sv/serial_setting_command_parser_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the serial setting command parser
// Concurrent checks are compiled in simulation and drop out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SERIAL_SETTING_COMMAND_PARSER_UNIT_DEFINES_SVH
`define SERIAL_SETTING_COMMAND_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Property must hold on every clock edge outside reset.
`define SSC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ssc assertion failed");
// Condition must never be seen outside reset.
`define SSC_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("ssc forbidden condition seen");
`else
`define SSC_ASSERT(name, prop)
`define SSC_ASSERT_NEVER(name, cond)
`endif

`endif

// ----- sv/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants and the result type of the serial setting command parser.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned LINE_BYTES_DEF = 64;

  localparam logic [15:0] PERIOD_MIN   = 16'd500;
  localparam logic [15:0] PERIOD_MAX   = 16'd60000;
  localparam logic [6:0]  THRESH_MAX   = 7'd99;
  localparam logic [15:0] PERIOD_RESET = 16'd4000;
  localparam logic [6:0]  TEMP_RESET   = 7'd29;
  localparam logic [6:0]  HUM_RESET    = 7'd70;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_FMT = 1'b1;

  typedef struct packed {
    logic        status;
    logic [15:0] period;
    logic [6:0]  temp;
    logic [6:0]  hum;
  } ssc_result_t;

endpackage

// ----- sv/ssc_in_stage.sv -----
// ----------------------------------------------------------------------------
// ssc_in_stage
// Input register: holds one received byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module ssc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic [7:0] s_tdata_i,
  output logic       s_tready_o,
  input  logic       take_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       vld_q;
  logic [7:0] byte_q;

  // The register can load whenever it is empty or its byte leaves this cycle.
  assign s_tready_o   = !vld_q || take_i;
  assign byte_valid_o = vld_q;
  assign byte_o       = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_tready_o) begin
      vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      byte_q <= s_tdata_i;
    end
  end

endmodule

// ----- sv/ssc_parse_core.sv -----
// ----------------------------------------------------------------------------
// ssc_parse_core
// Per-byte token parser, pending updates and committed settings.
// ----------------------------------------------------------------------------
module ssc_parse_core #(
  parameter int unsigned LINE_BYTES = ssc_pkg::LINE_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output ssc_pkg::ssc_result_t res_o
);
  import ssc_pkg::*;

  localparam int unsigned LcW = $clog2(LINE_BYTES);
  localparam logic [LcW-1:0] LcLast = LcW'(LINE_BYTES - 1);

  typedef enum logic [2:0] {
    PH_BETWEEN, PH_UPPER, PH_LOWER, PH_SPACE,
    PH_SIGN, PH_DIGITS, PH_TAIL, PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {KIND_NONE, KIND_P, KIND_T, KIND_H} kind_e;

  localparam logic [32:0] AccSat = 33'h1_0000_0000;

  logic [LcW-1:0] line_cnt_q, line_cnt_d;
  logic [15:0]    period_q, period_d, pend_period_q, pend_period_d;
  logic [6:0]     temp_q, temp_d, pend_temp_q, pend_temp_d;
  logic [6:0]     hum_q, hum_d, pend_hum_q, pend_hum_d;
  logic [2:0]     marks_q, marks_d;
  phase_e         phase_q, phase_d;
  kind_e          kind_q, kind_d;
  logic [32:0]    acc_q, acc_d;
  logic           minus_q, minus_d;
  logic           ended_q, ended_d;

  // Byte classification.
  logic       is_term, is_digit, is_delim, is_nul, is_fill;
  logic [3:0] digit;
  assign is_term  = (byte_i == 8'h0A) || (byte_i == 8'h0D) || (byte_i == 8'h3B);
  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_delim = (byte_i == 8'h20) || (byte_i == 8'h2C);
  assign is_nul   = (byte_i == 8'h00);
  assign is_fill  = (byte_i == 8'h09) || (byte_i == 8'h0B) || (byte_i == 8'h0C);
  assign digit    = byte_i[3:0];

  // Accumulate one decimal digit, saturating just above 32 bits.
  logic [36:0] acc_x10;
  logic [32:0] acc_next;
  assign acc_x10  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 37'(digit);
  assign acc_next = (acc_x10 > 37'(AccSat)) ? AccSat : acc_x10[32:0];

  // Value of the token that ends now, read as a 32-bit unsigned number.
  logic [31:0] tok_val;
  logic        tok_fin;
  assign tok_val = acc_q[32] ? 32'hFFFF_FFFF :
                   (minus_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0]);
  assign tok_fin = (phase_q == PH_DIGITS) || (phase_q == PH_TAIL);

  // Pending updates with the current token folded in.
  logic [15:0] ap_period;
  logic [6:0]  ap_temp, ap_hum;
  logic [2:0]  ap_marks;
  always_comb begin
    ap_period = pend_period_q;
    ap_temp   = pend_temp_q;
    ap_hum    = pend_hum_q;
    ap_marks  = marks_q;
    if (tok_fin) begin
      unique case (kind_q)
        KIND_P: begin
          if (tok_val < 32'(PERIOD_MIN)) begin
            ap_period = PERIOD_MIN;
          end else if (tok_val > 32'(PERIOD_MAX)) begin
            ap_period = PERIOD_MAX;
          end else begin
            ap_period = tok_val[15:0];
          end
          ap_marks[0] = 1'b1;
        end
        KIND_T: begin
          if (tok_val <= 32'(THRESH_MAX)) begin
            ap_temp     = tok_val[6:0];
            ap_marks[1] = 1'b1;
          end
        end
        KIND_H: begin
          if (tok_val <= 32'(THRESH_MAX)) begin
            ap_hum      = tok_val[6:0];
            ap_marks[2] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  logic        do_clear, do_end;
  logic [2:0]  c_marks;
  logic [15:0] c_period;
  logic [6:0]  c_temp, c_hum;

  always_comb begin
    line_cnt_d    = line_cnt_q;
    period_d      = period_q;
    temp_d        = temp_q;
    hum_d         = hum_q;
    pend_period_d = pend_period_q;
    pend_temp_d   = pend_temp_q;
    pend_hum_d    = pend_hum_q;
    marks_d       = marks_q;
    phase_d       = phase_q;
    kind_d        = kind_q;
    acc_d         = acc_q;
    minus_d       = minus_q;
    ended_d       = ended_q;
    do_clear      = 1'b0;
    do_end        = 1'b0;
    res_valid_o   = 1'b0;
    c_marks       = ended_q ? marks_q : ap_marks;
    c_period      = ended_q ? pend_period_q : ap_period;
    c_temp        = ended_q ? pend_temp_q : ap_temp;
    c_hum         = ended_q ? pend_hum_q : ap_hum;

    if (step_i) begin
      if (is_term) begin
        if (line_cnt_q != '0) begin
          if (c_marks[0]) period_d = c_period;
          if (c_marks[1]) temp_d = c_temp;
          if (c_marks[2]) hum_d = c_hum;
          res_valid_o = 1'b1;
          do_clear    = 1'b1;
        end
      end else if (line_cnt_q < LcLast) begin
        line_cnt_d = line_cnt_q + 1'b1;
        if (!ended_q) begin
          if (is_nul) begin
            do_end  = 1'b1;
            ended_d = 1'b1;
          end else if (is_delim) begin
            do_end = 1'b1;
          end else begin
            unique case (phase_q)
              PH_BETWEEN: begin
                priority if (byte_i == 8'h50 || byte_i == 8'h70) begin
                  kind_d = KIND_P;
                end else if (byte_i == 8'h54 || byte_i == 8'h74) begin
                  kind_d = KIND_T;
                end else if (byte_i == 8'h48 || byte_i == 8'h68) begin
                  kind_d = KIND_H;
                end else begin
                  kind_d = KIND_NONE;
                end
                if (kind_d == KIND_NONE) begin
                  phase_d = PH_SKIP;
                end else begin
                  // Lower case letters sit at bit 5 set.
                  phase_d = byte_i[5] ? PH_LOWER : PH_UPPER;
                end
              end
              PH_UPPER, PH_SPACE: begin
                priority if (phase_q == PH_UPPER && byte_i == 8'h3D) begin
                  phase_d = PH_SPACE;
                end else if (is_fill) begin
                  phase_d = PH_SPACE;
                end else if (byte_i == 8'h2B) begin
                  phase_d = PH_SIGN;
                end else if (byte_i == 8'h2D) begin
                  minus_d = 1'b1;
                  phase_d = PH_SIGN;
                end else if (is_digit) begin
                  acc_d   = 33'(digit);
                  phase_d = PH_DIGITS;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
              PH_LOWER: begin
                phase_d = (byte_i == 8'h3D) ? PH_SPACE : PH_SKIP;
              end
              PH_SIGN: begin
                if (is_digit) begin
                  acc_d   = 33'(digit);
                  phase_d = PH_DIGITS;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  acc_d = acc_next;
                end else begin
                  phase_d = PH_TAIL;
                end
              end
              default: ;
            endcase
          end
        end
      end else begin
        do_clear = 1'b1;
      end
    end

    if (do_end) begin
      pend_period_d = ap_period;
      pend_temp_d   = ap_temp;
      pend_hum_d    = ap_hum;
      marks_d       = ap_marks;
      phase_d       = PH_BETWEEN;
      kind_d        = KIND_NONE;
      acc_d         = '0;
      minus_d       = 1'b0;
    end
    if (do_clear) begin
      line_cnt_d    = '0;
      pend_period_d = '0;
      pend_temp_d   = '0;
      pend_hum_d    = '0;
      marks_d       = '0;
      phase_d       = PH_BETWEEN;
      kind_d        = KIND_NONE;
      acc_d         = '0;
      minus_d       = 1'b0;
      ended_d       = 1'b0;
    end
  end

  always_comb begin
    res_o.status = (c_marks == 3'b000) ? STATUS_FMT : STATUS_OK;
    res_o.period = period_d;
    res_o.temp   = temp_d;
    res_o.hum    = hum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q    <= '0;
      period_q      <= PERIOD_RESET;
      temp_q        <= TEMP_RESET;
      hum_q         <= HUM_RESET;
      pend_period_q <= '0;
      pend_temp_q   <= '0;
      pend_hum_q    <= '0;
      marks_q       <= '0;
      phase_q       <= PH_BETWEEN;
      kind_q        <= KIND_NONE;
      acc_q         <= '0;
      minus_q       <= 1'b0;
      ended_q       <= 1'b0;
    end else begin
      line_cnt_q    <= line_cnt_d;
      period_q      <= period_d;
      temp_q        <= temp_d;
      hum_q         <= hum_d;
      pend_period_q <= pend_period_d;
      pend_temp_q   <= pend_temp_d;
      pend_hum_q    <= pend_hum_d;
      marks_q       <= marks_d;
      phase_q       <= phase_d;
      kind_q        <= kind_d;
      acc_q         <= acc_d;
      minus_q       <= minus_d;
      ended_q       <= ended_d;
    end
  end

endmodule

// ----- sv/serial_setting_command_parser_unit.sv -----
// ----------------------------------------------------------------------------
// serial_setting_command_parser_unit
// Parses serial command lines that set the period and alarm thresholds.
// ----------------------------------------------------------------------------
// Feed received serial bytes in one per item on the slave stream; the block
// answers every nonempty line (ended by CR, LF or ';') with one result item
// carrying the status (OK when at least one P, T or H setting was accepted,
// FORMAT error otherwise) and the period and thresholds now in force. Empty
// lines give no result, and a line that holds LINE_BYTES-1 stored bytes is
// thrown away by the next byte that is not a terminator. Throughput is one
// byte per clock cycle: a new item is taken every cycle as long as the
// result register is free or being read. A terminator accepted into the input
// register is worked on there by the combinational parse stage, and its
// result is loaded into the result register when that byte steps through,
// from which it is offered on the master stream. The parse stage's
// multiply-by-ten accumulate, token value conversion and clamping are all
// combinational. Backpressure on the master stream stalls the parser one
// item at a time; nothing is lost or repeated.
`include "serial_setting_command_parser_unit_defines.svh"

module serial_setting_command_parser_unit #(
  parameter int unsigned LINE_BYTES = ssc_pkg::LINE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] period_value, [22:16] temp_threshold,
                                      // [29:23] hum_threshold, [31:30] zero
  output logic        m_axis_tuser    // [0] status: 0 = OK, 1 = format error
);
  import ssc_pkg::*;

  logic        byte_valid;
  logic [7:0]  byte_val;
  logic        step;
  logic        res_valid;
  ssc_result_t res;

  logic        out_valid_q, out_valid_d;
  ssc_result_t out_q;

  // A byte moves into the parse stage when the result register can take
  // whatever it might produce: empty now, or emptied at this same edge.
  assign step = byte_valid && (!out_valid_q || m_axis_tready);

  ssc_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tdata_i   (s_axis_tdata),
    .s_tready_o  (s_axis_tready),
    .take_i      (step),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_val)
  );

  ssc_parse_core #(
    .LINE_BYTES(LINE_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (byte_val),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {2'b00, out_q.hum, out_q.temp, out_q.period};

  // The parse stage must never run while a result waits untaken.
  `SSC_ASSERT_NEVER(a_no_overwrite, step && out_valid_q && !m_axis_tready)
  // Reported settings always lie in their legal ranges.
  `SSC_ASSERT(a_out_range, m_axis_tvalid |-> (out_q.period >= PERIOD_MIN &&
    out_q.period <= PERIOD_MAX && out_q.temp <= THRESH_MAX && out_q.hum <= THRESH_MAX))
  // A new result only comes from a byte that went through the parse stage.
  `SSC_ASSERT(a_result_source, $rose(m_axis_tvalid) |-> $past(step && res_valid))

endmodule
